// ===== src/fpw_pkg.sv =====
// shared types, codes and constants of the packed framebuffer pixel writer
package fpw_pkg;

  localparam int MAX_DIM      = 1024;
  localparam int CRD_W        = $clog2(MAX_DIM);
  localparam int DIM_W        = CRD_W + 1;
  localparam int PIX_W        = 24;
  localparam int FB_BYTES_DEF = 131072;
  localparam int QUEUE_DEPTH  = 4;
  localparam int PADDR_W      = 4;
  localparam int PDATA_W      = 32;

  localparam logic [1:0] MODE_MONO   = 2'd0;
  localparam logic [1:0] MODE_GREY   = 2'd1;
  localparam logic [1:0] MODE_RGB565 = 2'd2;
  localparam logic [1:0] MODE_RGB888 = 2'd3;

  localparam logic REQ_AREA  = 1'b0;
  localparam logic REQ_PIXEL = 1'b1;

  localparam logic [1:0] REG_PIXEL_MODE = 2'd0;
  localparam logic [1:0] REG_FB_WIDTH   = 2'd1;
  localparam logic [1:0] REG_FB_HEIGHT  = 2'd2;
  localparam logic [1:0] REG_SWAP_BYTES = 2'd3;

  localparam logic [1:0]       RST_PIXEL_MODE = MODE_RGB565;
  localparam logic [DIM_W-1:0] RST_FB_WIDTH   = DIM_W'(240);
  localparam logic [DIM_W-1:0] RST_FB_HEIGHT  = DIM_W'(240);

  localparam logic [15:0] MONO_LIMIT = 16'h8FFF;
  localparam logic [1:0]  GREY_MASK  = 2'h3;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_RMW  = 2'd1;
  localparam logic [1:0] KIND_COPY = 2'd2;

  typedef struct packed {
    logic [1:0]       pixel_mode;
    logic [DIM_W-1:0] fb_width;
    logic [DIM_W-1:0] fb_height;
    logic             swap_bytes;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  mask;
    logic [23:0] bytes;
    logic        three;
  } entry_t;

endpackage

// ===== src/fpw_regs.sv =====
// configuration registers behind the apb port
module fpw_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [fpw_pkg::PADDR_W-1:0]      paddr,
  input  logic [fpw_pkg::PDATA_W-1:0]      pwdata,
  output logic [fpw_pkg::PDATA_W-1:0]      prdata,
  output logic                             pready,
  output fpw_pkg::cfg_t                    cfg
);

  logic       wr_en;
  logic [1:0] reg_index;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite && pready;
  assign reg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_mode <= fpw_pkg::RST_PIXEL_MODE;
      cfg.fb_width   <= fpw_pkg::RST_FB_WIDTH;
      cfg.fb_height  <= fpw_pkg::RST_FB_HEIGHT;
      cfg.swap_bytes <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_index)
        fpw_pkg::REG_PIXEL_MODE: cfg.pixel_mode <= pwdata[1:0];
        fpw_pkg::REG_FB_WIDTH:   cfg.fb_width   <= pwdata[fpw_pkg::DIM_W-1:0];
        fpw_pkg::REG_FB_HEIGHT:  cfg.fb_height  <= pwdata[fpw_pkg::DIM_W-1:0];
        default:                 cfg.swap_bytes <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      fpw_pkg::REG_PIXEL_MODE: prdata = fpw_pkg::PDATA_W'(cfg.pixel_mode);
      fpw_pkg::REG_FB_WIDTH:   prdata = fpw_pkg::PDATA_W'(cfg.fb_width);
      fpw_pkg::REG_FB_HEIGHT:  prdata = fpw_pkg::PDATA_W'(cfg.fb_height);
      default:                 prdata = fpw_pkg::PDATA_W'(cfg.swap_bytes);
    endcase
  end

endmodule

// ===== src/fpw_front.sv =====
// front end: accepts items, walks the area cursor, computes byte address and merge data
module fpw_front #(
  parameter int FB_BYTES = fpw_pkg::FB_BYTES_DEF,
  parameter int ADDR_W   = $clog2(FB_BYTES)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fpw_pkg::cfg_t                 cfg,
  input  logic                          hold,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          req_type,
  input  logic [fpw_pkg::CRD_W-1:0]     x_first,
  input  logic [fpw_pkg::CRD_W-1:0]     y_first,
  input  logic [fpw_pkg::CRD_W-1:0]     x_last,
  input  logic [fpw_pkg::CRD_W-1:0]     y_last,
  input  logic [fpw_pkg::PIX_W-1:0]     pixel,
  output logic                          push_valid,
  input  logic                          push_ready,
  output fpw_pkg::entry_t               push_entry,
  output logic [ADDR_W-1:0]             push_addr
);

  localparam int CRD_W  = fpw_pkg::CRD_W;
  localparam int STR_W  = fpw_pkg::DIM_W + 2;
  localparam int PROD_W = CRD_W + STR_W;
  localparam int XO_W   = CRD_W + 2;
  localparam int FULL_W = PROD_W + 1;
  localparam logic [FULL_W-1:0] LIM_ONE   = FULL_W'(FB_BYTES);
  localparam logic [FULL_W-1:0] LIM_TWO   = FULL_W'(FB_BYTES - 2);
  localparam logic [FULL_W-1:0] LIM_THREE = FULL_W'(FB_BYTES - 3);

  // cursor state
  logic [CRD_W-1:0] cursor_x;
  logic [CRD_W-1:0] cursor_y;
  logic [CRD_W-1:0] row_start;
  logic [CRD_W-1:0] row_end;
  logic [CRD_W-1:0] area_bottom;
  logic             area_done;

  // stage one
  logic              s1_valid;
  logic              s1_ack;
  logic [1:0]        s1_mode;
  logic [PROD_W-1:0] s1_prod;
  logic [XO_W-1:0]   s1_xoff;
  logic [7:0]        s1_mask;
  logic [23:0]       s1_bytes;

  logic              accept;
  logic              is_pixel;
  logic              on_screen;
  logic [STR_W-1:0]  w_ext;
  logic [STR_W-1:0]  stride;
  logic [PROD_W-1:0] prod;
  logic [XO_W-1:0]   x_ext;
  logic [XO_W-1:0]   xoff;
  logic [7:0]        gsum;
  logic [1:0]        grey_val;
  logic [2:0]        grey_sh;
  logic [7:0]        mask;
  logic [23:0]       bytes;
  logic [FULL_W-1:0] addr_full;
  logic              fits;

  assign in_ready = !hold && (!s1_valid || push_ready);
  assign accept   = in_valid && in_ready;
  assign is_pixel = (req_type == fpw_pkg::REQ_PIXEL);
  assign on_screen = ({1'b0, cursor_x} < cfg.fb_width) && ({1'b0, cursor_y} < cfg.fb_height);

  assign w_ext   = STR_W'(cfg.fb_width);
  assign x_ext   = XO_W'(cursor_x);
  assign gsum    = 8'(pixel[15:11]) + 8'({pixel[10:5], 1'b0}) + 8'(pixel[4:0]);
  assign grey_val = ~gsum[3:2];
  assign grey_sh = {cursor_x[1:0], 1'b0};
  assign prod    = cursor_y * stride;

  always_comb begin
    unique case (cfg.pixel_mode)
      fpw_pkg::MODE_MONO: begin
        stride = (w_ext + STR_W'(7)) >> 3;
        xoff   = x_ext >> 3;
        mask   = 8'd1 << cursor_x[2:0];
        bytes  = 24'((pixel[15:0] <= fpw_pkg::MONO_LIMIT) ? mask : 8'd0);
      end
      fpw_pkg::MODE_GREY: begin
        stride = (w_ext + STR_W'(3)) >> 2;
        xoff   = x_ext >> 2;
        mask   = 8'(fpw_pkg::GREY_MASK) << grey_sh;
        bytes  = 24'(8'(grey_val) << grey_sh);
      end
      fpw_pkg::MODE_RGB565: begin
        stride = w_ext << 1;
        xoff   = x_ext << 1;
        mask   = 8'hFF;
        bytes  = cfg.swap_bytes ? {8'd0, pixel[7:0], pixel[15:8]} : pixel;
      end
      default: begin
        stride = w_ext + (w_ext << 1);
        xoff   = x_ext + (x_ext << 1);
        mask   = 8'hFF;
        bytes  = pixel;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x    <= '0;
      cursor_y    <= '0;
      row_start   <= '0;
      row_end     <= '0;
      area_bottom <= '0;
      area_done   <= 1'b0;
      s1_valid    <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (push_ready) begin
        s1_valid <= 1'b0;
      end
      if (accept && !is_pixel) begin
        row_start   <= x_first;
        cursor_x    <= x_first;
        cursor_y    <= y_first;
        row_end     <= x_last;
        area_bottom <= y_last;
        area_done   <= (y_first > y_last);
      end else if (accept && !area_done) begin
        if (cursor_x >= row_end) begin
          cursor_x <= row_start;
          if (cursor_y >= area_bottom) begin
            area_done <= 1'b1;
          end else begin
            cursor_y <= cursor_y + CRD_W'(1);
          end
        end else begin
          cursor_x <= cursor_x + CRD_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ack   <= !is_pixel || area_done || !on_screen;
      s1_mode  <= cfg.pixel_mode;
      s1_prod  <= prod;
      s1_xoff  <= xoff;
      s1_mask  <= mask;
      s1_bytes <= bytes;
    end
  end

  // stage two: final address and range check
  assign addr_full = FULL_W'(s1_prod) + FULL_W'(s1_xoff);

  always_comb begin
    unique case (s1_mode)
      fpw_pkg::MODE_RGB565: fits = (addr_full <= LIM_TWO);
      fpw_pkg::MODE_RGB888: fits = (addr_full <= LIM_THREE);
      default:              fits = (addr_full < LIM_ONE);
    endcase
  end

  always_comb begin
    push_valid       = s1_valid;
    push_entry.mask  = s1_mask;
    push_entry.bytes = s1_bytes;
    push_entry.three = (s1_mode == fpw_pkg::MODE_RGB888);
    push_addr        = addr_full[ADDR_W-1:0];
    if (s1_ack || !fits) begin
      push_entry.kind = fpw_pkg::KIND_ACK;
      push_addr       = '0;
    end else if (s1_mode == fpw_pkg::MODE_MONO || s1_mode == fpw_pkg::MODE_GREY) begin
      push_entry.kind = fpw_pkg::KIND_RMW;
    end else begin
      push_entry.kind = fpw_pkg::KIND_COPY;
    end
  end

endmodule

// ===== src/fpw_queue.sv =====
// small fifo between front and back end
module fpw_queue #(
  parameter int W     = 8,
  parameter int DEPTH = fpw_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== src/fpw_back.sv =====
// back end: framebuffer memory, clear sweep, read-modify-write and byte beats
module fpw_back #(
  parameter int FB_BYTES = fpw_pkg::FB_BYTES_DEF,
  parameter int ADDR_W   = $clog2(FB_BYTES)
) (
  input  logic                clk,
  input  logic                rst,
  output logic                clearing,
  input  logic                head_valid,
  input  fpw_pkg::entry_t     head_entry,
  input  logic [ADDR_W-1:0]   head_addr,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ADDR_W-1:0]   out_addr,
  output logic [7:0]          out_data,
  output logic                out_written,
  output logic                out_last
);

  logic [7:0]        mem [FB_BYTES];
  logic [7:0]        rdata;
  logic [ADDR_W-1:0] clr_addr;

  logic              m_valid;
  fpw_pkg::entry_t   m_entry;
  logic [ADDR_W-1:0] m_addr;
  logic [1:0]        beat;
  logic              fwd_hit;
  logic [7:0]        fwd_data;

  logic              out_load;
  logic              m_fire;
  logic              last_beat;
  logic              m_done;
  logic [7:0]        old_byte;
  logic [7:0]        new_byte;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;

  assign out_load  = !out_valid || out_ready;
  assign m_fire    = m_valid && out_load;
  assign last_beat = (m_entry.kind != fpw_pkg::KIND_COPY) ||
                     (m_entry.three ? (beat == 2'd2) : (beat == 2'd1));
  assign m_done    = m_fire && last_beat;
  assign pop       = head_valid && (!m_valid || m_done);
  assign old_byte  = fwd_hit ? fwd_data : rdata;

  always_comb begin
    unique case (m_entry.kind)
      fpw_pkg::KIND_ACK: new_byte = 8'd0;
      fpw_pkg::KIND_RMW: new_byte = (old_byte & ~m_entry.mask) |
                                    (m_entry.bytes[7:0] & m_entry.mask);
      default: begin
        unique case (beat)
          2'd0:    new_byte = m_entry.bytes[7:0];
          2'd1:    new_byte = m_entry.bytes[15:8];
          default: new_byte = m_entry.bytes[23:16];
        endcase
      end
    endcase
  end

  always_comb begin
    if (clearing) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr;
      wr_data = 8'd0;
    end else begin
      wr_en   = m_fire && (m_entry.kind != fpw_pkg::KIND_ACK);
      wr_addr = m_addr + ADDR_W'(beat);
      wr_data = new_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (pop) begin
      rdata <= mem[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_addr  <= '0;
      m_valid   <= 1'b0;
      beat      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(FB_BYTES - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (pop) begin
        m_valid <= 1'b1;
      end else if (m_done) begin
        m_valid <= 1'b0;
      end
      if (m_done) begin
        beat <= '0;
      end else if (m_fire) begin
        beat <= beat + 2'd1;
      end
      if (m_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_entry  <= head_entry;
      m_addr   <= head_addr;
      // a write landing on the same edge as the read is not seen by the read
      fwd_hit  <= wr_en && (wr_addr == head_addr);
      fwd_data <= wr_data;
    end
    if (m_fire) begin
      out_written <= (m_entry.kind != fpw_pkg::KIND_ACK);
      out_addr    <= (m_entry.kind == fpw_pkg::KIND_ACK) ? '0 : wr_addr;
      out_data    <= new_byte;
      out_last    <= last_beat;
    end
  end

endmodule

// ===== src/packed_framebuffer_pixel_writer.sv =====
// Packed framebuffer pixel writer. A set-area item loads a rectangle and
// each later pixel item is stored at a cursor walking that rectangle, into
// a byte framebuffer held inside the block, packed as mono 1bpp, two-bit
// grey, RGB565 or RGB888. Every byte written comes out as one beat with
// tuser high; set-area items and dropped pixels give one beat with tuser
// low and zero data; tlast marks the final beat of an item. Input items are
// taken one per cycle while the queue has room; the result channel then sets
// the rate at one beat per cycle while m_tready is high. Set area, mono and
// grey items give one beat, RGB565 two and RGB888 three. A four-entry queue
// sits between the address pipeline and the memory back end; an item passes
// stage one, the queue and the read stage before its first beat is
// registered. After reset all FB_BYTES bytes (131072 by default) are zeroed
// one per cycle with s_tready low; register writes are taken at any time.
module packed_framebuffer_pixel_writer #(
  parameter int FB_BYTES    = fpw_pkg::FB_BYTES_DEF,
  parameter int QUEUE_DEPTH = fpw_pkg::QUEUE_DEPTH,
  parameter int ADDR_W      = $clog2(FB_BYTES),
  parameter int OUT_DW      = ((ADDR_W + 8 + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fpw_pkg::PADDR_W-1:0]   paddr,
  input  logic [fpw_pkg::PDATA_W-1:0]   pwdata,
  output logic [fpw_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // x_first, y_first, x_last, y_last, pixel
  input  logic [63:0]                   s_tdata,
  // req_type
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // write_address, write_data, zero fill
  output logic [OUT_DW-1:0]             m_tdata,
  // written
  output logic                          m_tuser,
  output logic                          m_tlast
);

  localparam int QW = $bits(fpw_pkg::entry_t) + ADDR_W;

  fpw_pkg::cfg_t     cfg;
  logic              clearing;
  logic              push_valid;
  logic              push_ready;
  fpw_pkg::entry_t   push_entry;
  logic [ADDR_W-1:0] push_addr;
  logic              head_valid;
  logic [QW-1:0]     head_word;
  fpw_pkg::entry_t   head_entry;
  logic [ADDR_W-1:0] head_addr;
  logic              pop;
  logic [ADDR_W-1:0] out_addr;
  logic [7:0]        out_data;

  assign {head_entry, head_addr} = head_word;
  assign m_tdata = OUT_DW'({out_data, out_addr});

  fpw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fpw_front #(
    .FB_BYTES (FB_BYTES),
    .ADDR_W   (ADDR_W)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .hold       (clearing),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .req_type   (s_tuser),
    .x_first    (s_tdata[9:0]),
    .y_first    (s_tdata[19:10]),
    .x_last     (s_tdata[29:20]),
    .y_last     (s_tdata[39:30]),
    .pixel      (s_tdata[63:40]),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .push_addr  (push_addr)
  );

  fpw_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_entry, push_addr}),
    .pop_valid  (head_valid),
    .pop        (pop),
    .pop_data   (head_word)
  );

  fpw_back #(
    .FB_BYTES (FB_BYTES),
    .ADDR_W   (ADDR_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .clearing    (clearing),
    .head_valid  (head_valid),
    .head_entry  (head_entry),
    .head_addr   (head_addr),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_addr    (out_addr),
    .out_data    (out_data),
    .out_written (m_tuser),
    .out_last    (m_tlast)
  );

endmodule

// ===== src/fpw_checker.sv =====
// port-level checks of the pixel writer, bound to the top level
module fpw_port_checks #(
  parameter int FB_BYTES = fpw_pkg::FB_BYTES_DEF,
  parameter int ADDR_W   = $clog2(FB_BYTES),
  parameter int OUT_DW   = ((ADDR_W + 8 + 7) / 8) * 8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [OUT_DW-1:0]             m_tdata,
  input logic                          m_tuser,
  input logic                          m_tlast
);

  // held beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
                              $stable(m_tlast))
    else $error("result beat changed while stalled");

  // no input taken right after reset while the framebuffer is cleared
  a_clear_blocks: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input accepted during clear sweep");

  // acknowledge and dropped pixel beats are single and zero
  a_ack_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast && (m_tdata == '0))
    else $error("non-write beat not zero or not last");

  // copy beats follow at once, at the next byte address
  a_copy_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tuser && !m_tlast |=>
      m_tvalid && m_tuser &&
      (m_tdata[ADDR_W-1:0] == $past(m_tdata[ADDR_W-1:0]) + ADDR_W'(1)))
    else $error("copy beat run broken");

endmodule

bind packed_framebuffer_pixel_writer fpw_port_checks #(
  .FB_BYTES (FB_BYTES)
) u_fpw_port_checks (.*);

// ===== dv/fpw_checker.sv =====
// checker for the packed framebuffer pixel writer: tracks registers, predicts and compares beats
module fpw_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [fpw_pkg::PADDR_W-1:0] paddr,
  input  logic [fpw_pkg::PDATA_W-1:0] pwdata,
  input  logic                        s_tvalid,
  input  logic                        s_tready,
  input  logic [63:0]                 s_tdata,
  input  logic                        s_tuser,
  input  logic                        m_tvalid,
  input  logic                        m_tready,
  input  logic [31:0]                 m_tdata,
  input  logic                        m_tuser,
  input  logic                        m_tlast,
  output int                          mismatch_count,
  output int                          writes_outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import fpw_pkg::*;

  localparam int unsigned FB_LIMIT = FB_BYTES_DEF;

  typedef struct packed {
    logic [16:0] address;
    logic [7:0]  data;
    logic        written;
    logic        last;
  } byte_write_t;

  byte_write_t      expected_writes[$];
  byte_write_t      got_write;
  byte_write_t      want_write;
  logic [7:0]       frame_copy [FB_BYTES_DEF];
  cfg_t             cfg;
  logic [CRD_W-1:0] cur_x, cur_y, row_start, row_end, area_bottom;
  logic             area_done;
  int               errors;

  function automatic void queue_write(input int unsigned addr, input logic [7:0] data,
                                      input logic wr, input logic lst);
    byte_write_t w;
    w.address = 17'(addr);
    w.data    = data;
    w.written = wr;
    w.last    = lst;
    expected_writes.push_back(w);
  endfunction

  function automatic int field_differs(input string name, input logic [16:0] want,
                                       input logic [16:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  task automatic predict_writes(input logic kind, input logic [63:0] item);
    int unsigned px, py, width, addr, nbytes, lum, shift, i;
    logic [23:0] pix;
    logic [23:0] out_bytes;
    logic [7:0]  b;
    if (kind == REQ_AREA) begin
      row_start   = item[9:0];
      cur_y       = item[19:10];
      row_end     = item[29:20];
      area_bottom = item[39:30];
      cur_x       = row_start;
      area_done   = (cur_y > area_bottom);
      queue_write(0, 8'h00, 1'b0, 1'b1);
      return;
    end
    if (area_done) begin
      queue_write(0, 8'h00, 1'b0, 1'b1);
      return;
    end
    px    = cur_x;
    py    = cur_y;
    width = cfg.fb_width;
    pix   = item[63:40];
    if (cur_x >= row_end) begin
      cur_x = row_start;
      if (cur_y >= area_bottom) area_done = 1'b1;
      else cur_y = cur_y + 1'b1;
    end else begin
      cur_x = cur_x + 1'b1;
    end
    if (px >= width || py >= cfg.fb_height) begin
      queue_write(0, 8'h00, 1'b0, 1'b1);
      return;
    end
    case (cfg.pixel_mode)
      MODE_MONO: begin
        addr = py * ((width + 7) >> 3) + (px >> 3);
        if (addr >= FB_LIMIT) begin
          queue_write(0, 8'h00, 1'b0, 1'b1);
        end else begin
          b = frame_copy[addr];
          b[px % 8] = (pix[15:0] <= MONO_LIMIT);
          frame_copy[addr] = b;
          queue_write(addr, b, 1'b1, 1'b1);
        end
      end
      MODE_GREY: begin
        addr = py * ((width + 3) >> 2) + (px >> 2);
        if (addr >= FB_LIMIT) begin
          queue_write(0, 8'h00, 1'b0, 1'b1);
        end else begin
          lum   = pix[15:11] + 2 * pix[10:5] + pix[4:0];
          shift = (px % 4) * 2;
          b = frame_copy[addr];
          b[shift +: 2] = 2'(~(lum >> 2)) & GREY_MASK;
          frame_copy[addr] = b;
          queue_write(addr, b, 1'b1, 1'b1);
        end
      end
      default: begin
        nbytes = (cfg.pixel_mode == MODE_RGB565) ? 2 : 3;
        addr   = (py * width + px) * nbytes;
        if (addr + nbytes > FB_LIMIT) begin
          queue_write(0, 8'h00, 1'b0, 1'b1);
        end else begin
          out_bytes = pix;
          if (nbytes == 2 && cfg.swap_bytes) out_bytes[15:0] = {pix[7:0], pix[15:8]};
          for (i = 0; i < nbytes; i++) begin
            frame_copy[addr + i] = out_bytes[8*i +: 8];
            queue_write(addr + i, out_bytes[8*i +: 8], 1'b1, i == nbytes - 1);
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      foreach (frame_copy[i]) frame_copy[i] = 8'h00;
      cfg         = '{RST_PIXEL_MODE, RST_FB_WIDTH, RST_FB_HEIGHT, 1'b0};
      cur_x       = '0;
      cur_y       = '0;
      row_start   = '0;
      row_end     = '0;
      area_bottom = '0;
      area_done   = 1'b0;
      errors      = 0;
      expected_writes.delete();
      mismatch_count     <= 0;
      writes_outstanding <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_PIXEL_MODE: cfg.pixel_mode = pwdata[1:0];
          REG_FB_WIDTH:   cfg.fb_width   = pwdata[DIM_W-1:0];
          REG_FB_HEIGHT:  cfg.fb_height  = pwdata[DIM_W-1:0];
          REG_SWAP_BYTES: cfg.swap_bytes = pwdata[0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) predict_writes(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got_write = '{m_tdata[16:0], m_tdata[24:17], m_tuser, m_tlast};
        if (expected_writes.size() == 0) begin
          $display("%0t: beat with nothing expected, addr %h data %h written %b last %b",
                   $time, got_write.address, got_write.data, got_write.written,
                   got_write.last);
          errors++;
        end else begin
          want_write = expected_writes.pop_front();
          errors += field_differs("write_address", want_write.address, got_write.address);
          errors += field_differs("write_data", want_write.data, got_write.data);
          errors += field_differs("written", want_write.written, got_write.written);
          errors += field_differs("last", want_write.last, got_write.last);
        end
      end
      mismatch_count     <= errors;
      writes_outstanding <= expected_writes.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// top of the packed framebuffer pixel writer testbench: stimulus, register setup and verdict
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fpw_pkg::*;

  localparam int STALL_LIMIT     = 400000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 28;

  logic               clk;
  logic               rst      = 1'b1;
  logic               psel     = 1'b0;
  logic               penable  = 1'b0;
  logic               pwrite   = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [PDATA_W-1:0] pwdata   = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [63:0]        s_tdata  = '0;
  logic               s_tuser  = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [31:0]        m_tdata;
  logic               m_tuser;
  logic               m_tlast;

  int         mismatch_count;
  int         writes_outstanding;
  int         src_idle     = 22;
  int         dst_idle     = 50;
  int         stall_cycles = 0;
  logic [1:0] fb_mode      = MODE_RGB565;
  int         fb_w         = 240;
  int         fb_h         = 240;

  packed_framebuffer_pixel_writer DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  fpw_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .mismatch_count(mismatch_count), .writes_outstanding(writes_outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) m_tready <= !rst && ($urandom_range(99) >= dst_idle);

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic kind, input logic [63:0] data);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic send_area(input int x0, input int y0, input int x1, input int y1);
    send_item(REQ_AREA, {24'($urandom), 10'(y1), 10'(x1), 10'(y0), 10'(x0)});
  endtask

  task automatic send_pixel(input logic [23:0] pix);
    send_item(REQ_PIXEL, {pix, 8'($urandom), 32'($urandom)});
  endtask

  function automatic logic [23:0] random_pixel();
    logic [23:0] v;
    v = 24'($urandom);
    if (fb_mode == MODE_MONO && $urandom_range(1) == 1)
      v[15:0] = 16'(int'(MONO_LIMIT) - 2 + $urandom_range(0, 4));
    return v;
  endfunction

  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (writes_outstanding != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [1:0] mode, input int w, input int h, input logic swap);
    write_reg(REG_PIXEL_MODE, int'(mode));
    write_reg(REG_FB_WIDTH, w);
    write_reg(REG_FB_HEIGHT, h);
    write_reg(REG_SWAP_BYTES, int'(swap));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    fb_mode = mode;
    fb_w    = w;
    fb_h    = h;
  endtask

  initial begin
    int p, sent, roll, x0, y0, x1, y1, npix, k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: rgb565 copy, 240 x 240
    send_area(0, 0, 2, 0);
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(random_pixel());
    send_pixel(random_pixel());
    send_area(1023, 1023, 1023, 1023);
    send_pixel(24'h5A5A5A);
    send_area(0, 5, 0, 4);
    send_pixel(random_pixel());
    send_area(5, 0, 2, 1);
    send_pixel(random_pixel());
    send_pixel(random_pixel());
    send_pixel(random_pixel());

    drain();
    set_frame(MODE_RGB888, 240, 240, 1'b1);
    send_area(239, 239, 239, 239);
    send_pixel(random_pixel());

    drain();
    set_frame(MODE_MONO, 1024, 1024, 1'b0);
    send_area(1022, 1023, 1023, 1023);
    send_pixel(24'hFF8FFF);
    send_pixel(24'h009000);

    drain();
    set_frame(MODE_GREY, 1024, 1024, 1'b0);
    send_area(1020, 1023, 1020, 1023);
    send_pixel(random_pixel());
    send_area(0, 0, 1, 0);
    send_pixel(24'h00FFFF);
    send_pixel(24'h000000);

    drain();
    set_frame(MODE_RGB565, 1, 1, 1'b1);
    send_area(0, 0, 0, 0);
    send_pixel(24'hA1B2C3);

    for (p = 0; p < PHASES; p++) begin
      drain();
      src_idle = (p < 2) ? 22 : (p < 4) ? 50 : 0;
      dst_idle = (p < 2) ? 50 : (p < 4) ? 22 : 0;
      case (p)
        0: set_frame(MODE_MONO, $urandom_range(1, 64), $urandom_range(1, 64), 1'($urandom));
        1: set_frame(MODE_GREY, 1, 1024, 1'($urandom));
        2: set_frame(MODE_RGB565, 1024, 1, 1'b1);
        3: set_frame(MODE_RGB888, $urandom_range(8, 100), $urandom_range(8, 100),
                     1'($urandom));
        4: set_frame(MODE_GREY, 1024, 1024, 1'b0);
        default: set_frame(MODE_RGB565, $urandom_range(1, 1024), $urandom_range(1, 1024), 1'b0);
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        roll = $urandom_range(99);
        if (roll < 10) begin
          send_item(REQ_AREA, {$urandom, $urandom});
          sent++;
        end else if (roll < 16) begin
          send_pixel(random_pixel());
          sent++;
        end else begin
          x0 = ($urandom_range(9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, fb_w - 1);
          y0 = ($urandom_range(9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, fb_h - 1);
          x1 = x0 + $urandom_range(0, 5);
          y1 = y0 + $urandom_range(0, 3);
          if (x1 > 1023) x1 = 1023;
          if (y1 > 1023) y1 = 1023;
          send_area(x0, y0, x1, y1);
          sent++;
          npix = (x1 - x0 + 1) * (y1 - y0 + 1);
          roll = $urandom_range(9);
          if (roll == 0) npix = npix + $urandom_range(1, 2);
          else if (roll == 1) npix = $urandom_range(0, npix);
          for (k = 0; k < npix; k++) begin
            send_pixel(random_pixel());
            sent++;
          end
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && writes_outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
